[hw/rtl/usb_remote_wake_controller_top_defines.svh]
// Assertion macros used by the remote-wake controller policy RTL.
// Stand-alone header; included by the files that carry assertions.
`ifndef USB_REMOTE_WAKE_CONTROLLER_TOP_DEFINES_SVH
`define USB_REMOTE_WAKE_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define USBRW_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define USBRW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/usbrw_pkg.sv]
// Package for the USB remote-wake controller: word types, codes and constants.
// No dependencies.
package usbrw_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam logic [7:0] IDLE_DPAD = 8'h08;
  localparam logic [9:0] MIN_REPORT_LEN = 10'd10;
  localparam logic [31:0] DEFAULT_DELAY_US = 32'd5000000;

  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_SUSPEND    = 3'd1,
    FN_RESUME     = 3'd2,
    FN_CONNECT    = 3'd3,
    FN_DISCONNECT = 3'd4,
    FN_REPORT     = 3'd5,
    FN_TAKE       = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PENDING   = 2'd1,
    PH_REQUESTED = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_WAKE_ENABLE     = 2'd0,
    CFG_POWEROFF_DELAY  = 2'd1,
    CFG_REQUEST_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_us;
    logic [9:0]  report_len;
    logic [7:0]  dpad_byte;
    logic [7:0]  button_byte_a;
    logic [7:0]  button_byte_b;
    logic        wakeup_accepted;
  } in_word_t;

  typedef struct packed {
    logic       wake_request;
    logic       wake_forced;
    logic       power_off;
    logic       radio_wake_taken;
    logic       suspended_now;
    logic [1:0] wake_phase;
  } out_word_t;

  typedef struct packed {
    logic        wake_enable;
    logic [31:0] poweroff_delay_us;
    logic [31:0] request_timeout_us;
  } cfg_t;

endpackage

[hw/rtl/usbrw_cfg_regs.sv]
// Configuration register file of the remote-wake controller.
// Depends on usbrw_pkg.
module usbrw_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output usbrw_pkg::cfg_t  cfg
);
  import usbrw_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_enable        <= 1'b1;
      cfg.poweroff_delay_us  <= DEFAULT_DELAY_US;
      cfg.request_timeout_us <= DEFAULT_DELAY_US;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WAKE_ENABLE:     cfg.wake_enable        <= cfg_data[0];
        CFG_POWEROFF_DELAY:  cfg.poweroff_delay_us  <= cfg_data;
        CFG_REQUEST_TIMEOUT: cfg.request_timeout_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/usbrw_policy.sv]
// Wake policy: state registers and the single-pass next-state logic.
// Depends on usbrw_pkg and usb_remote_wake_controller_top_defines.svh.
`include "usb_remote_wake_controller_top_defines.svh"

module usbrw_policy #(
  parameter int TIME_WIDTH = usbrw_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  usbrw_pkg::in_word_t  item,
  input  usbrw_pkg::cfg_t      cfg,
  output usbrw_pkg::out_word_t res
);
  import usbrw_pkg::*;

  // Compare width covers both the time difference and the 32-bit limits.
  localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  phase_t                phase, phase_next;
  logic                  host_is_suspended, host_is_suspended_next;
  logic                  host_has_resumed, host_has_resumed_next;
  logic [TIME_WIDTH-1:0] phase_start, phase_start_next;
  logic [TIME_WIDTH-1:0] suspend_start, suspend_start_next;
  logic                  powered_off, powered_off_next;
  logic                  radio_wake_owed, radio_wake_owed_next;
  logic [7:0]            last_dpad, last_dpad_next;
  logic [7:0]            last_buttons_a, last_buttons_a_next;
  logic [7:0]            last_buttons_b, last_buttons_b_next;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] since_suspend;
  logic [TIME_WIDTH-1:0] since_phase;
  logic                  poweroff_due;
  logic                  timed_out;
  logic                  armable;
  logic                  changed;
  logic                  req, forced, poff, taken;

  assign now_t         = TIME_WIDTH'(item.now_us);
  assign since_suspend = now_t - suspend_start;
  assign since_phase   = now_t - phase_start;
  assign poweroff_due  = CW'(since_suspend) >= CW'(cfg.poweroff_delay_us);
  assign timed_out     = CW'(since_phase) > CW'(cfg.request_timeout_us);
  assign armable       = (phase != PH_REQUESTED);
  assign changed       = (item.dpad_byte != last_dpad) ||
                         (item.button_byte_a != last_buttons_a) ||
                         (item.button_byte_b != last_buttons_b);

  always_comb begin
    phase_next             = phase;
    host_is_suspended_next = host_is_suspended;
    host_has_resumed_next  = host_has_resumed;
    phase_start_next       = phase_start;
    suspend_start_next     = suspend_start;
    powered_off_next       = powered_off;
    radio_wake_owed_next   = radio_wake_owed;
    last_dpad_next         = last_dpad;
    last_buttons_a_next    = last_buttons_a;
    last_buttons_b_next    = last_buttons_b;
    req    = 1'b0;
    forced = 1'b0;
    poff   = 1'b0;
    taken  = 1'b0;

    case (item.func)
      FN_TICK: begin
        if (host_is_suspended && !powered_off && poweroff_due) begin
          powered_off_next = 1'b1;
          poff             = 1'b1;
        end
        case (phase)
          PH_PENDING: begin
            if (!host_is_suspended) begin
              phase_next       = PH_DONE;
              phase_start_next = now_t;
            end
          end
          PH_REQUESTED: begin
            if (host_has_resumed || !host_is_suspended || timed_out) begin
              phase_next       = PH_DONE;
              phase_start_next = now_t;
            end
          end
          default: ;
        endcase
      end
      FN_SUSPEND: begin
        host_is_suspended_next = 1'b1;
        host_has_resumed_next  = 1'b0;
        suspend_start_next     = now_t;
        powered_off_next       = 1'b0;
        phase_next             = PH_PENDING;
        phase_start_next       = now_t;
        last_dpad_next         = IDLE_DPAD;
        last_buttons_a_next    = '0;
        last_buttons_b_next    = '0;
      end
      FN_RESUME: begin
        if (powered_off) radio_wake_owed_next = 1'b1;
        host_is_suspended_next = 1'b0;
        host_has_resumed_next  = 1'b1;
        suspend_start_next     = '0;
        powered_off_next       = 1'b0;
      end
      FN_CONNECT: begin
        // A wake is only ever asked while suspended, so a refusal forces it.
        if (host_is_suspended && armable && cfg.wake_enable) begin
          req              = 1'b1;
          forced           = !item.wakeup_accepted;
          phase_next       = PH_REQUESTED;
          phase_start_next = now_t;
        end
      end
      FN_DISCONNECT: begin
        phase_next          = PH_IDLE;
        last_dpad_next      = IDLE_DPAD;
        last_buttons_a_next = '0;
        last_buttons_b_next = '0;
      end
      FN_REPORT: begin
        if (item.report_len >= MIN_REPORT_LEN) begin
          last_dpad_next      = item.dpad_byte;
          last_buttons_a_next = item.button_byte_a;
          last_buttons_b_next = item.button_byte_b;
          if (changed && armable && host_is_suspended && cfg.wake_enable) begin
            req              = 1'b1;
            forced           = !item.wakeup_accepted;
            phase_next       = PH_REQUESTED;
            phase_start_next = now_t;
          end
        end
      end
      FN_TAKE: begin
        if (radio_wake_owed && !host_is_suspended) begin
          radio_wake_owed_next = 1'b0;
          taken                = 1'b1;
        end
      end
      default: ;
    endcase

    res.wake_request     = req;
    res.wake_forced      = forced;
    res.power_off        = poff;
    res.radio_wake_taken = taken;
    res.suspended_now    = host_is_suspended_next;
    res.wake_phase       = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      host_is_suspended <= 1'b0;
      host_has_resumed  <= 1'b0;
      phase_start       <= '0;
      suspend_start     <= '0;
      powered_off       <= 1'b0;
      radio_wake_owed   <= 1'b0;
      last_dpad         <= IDLE_DPAD;
      last_buttons_a    <= '0;
      last_buttons_b    <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      host_is_suspended <= host_is_suspended_next;
      host_has_resumed  <= host_has_resumed_next;
      phase_start       <= phase_start_next;
      suspend_start     <= suspend_start_next;
      powered_off       <= powered_off_next;
      radio_wake_owed   <= radio_wake_owed_next;
      last_dpad         <= last_dpad_next;
      last_buttons_a    <= last_buttons_a_next;
      last_buttons_b    <= last_buttons_b_next;
    end
  end

  `USBRW_ASSERT_NEXT(a_poweroff_latched, clk, rst, fire && res.power_off,
                     powered_off, "power-off pulse did not latch the powered-off flag")
  `USBRW_ASSERT_NEXT(a_request_phase, clk, rst, fire && res.wake_request,
                     phase == PH_REQUESTED && host_is_suspended,
                     "wake request did not enter the requested phase")
  `USBRW_ASSERT_NEXT(a_take_clears, clk, rst, fire && res.radio_wake_taken,
                     !radio_wake_owed, "taken radio wake is still owed")
  `USBRW_ASSERT_SAME(a_forced_needs_request, clk, rst, fire && res.wake_forced,
                     res.wake_request && !item.wakeup_accepted,
                     "forced wake without a refused request")

endmodule

[hw/rtl/usbrw_out_reg.sv]
// Result register with valid/ready hand-off to the consumer.
// Depends on usbrw_pkg.
module usbrw_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  usbrw_pkg::out_word_t load_data,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output usbrw_pkg::out_word_t out_data
);
  import usbrw_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

[hw/rtl/usb_remote_wake_controller_top.sv]
// Top level of the USB remote-wake controller: input register, policy, result register.
// Depends on usbrw_pkg, usbrw_cfg_regs, usbrw_policy and usbrw_out_reg.
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+--------------------------------
//   in       | input     | in_valid / in_ready  | in_data (in_word_t), one event
//   out      | output    | out_valid / out_ready| out_data (out_word_t), one result
//   cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every accepted word yields exactly one result word: it waits in the input register,
// where the policy logic evaluates it, and then moves on to the result register.
// Throughput is one word per cycle while out_ready stays high; the policy block
// updates its state as each word moves on to the result register.
// Reset is synchronous and active high; it empties both registers and returns the
// wake state and configuration to their defaults. cfg_ready is always high.
// When out_ready is low the result register holds its word; the input register
// still takes one more word, and in_ready drops only when both registers are full.

module usb_remote_wake_controller_top #(
  parameter int TIME_WIDTH = usbrw_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  usbrw_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output usbrw_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import usbrw_pkg::*;

  // Input register: holds the event that the policy is working on.
  logic      item_valid;
  in_word_t  item;
  logic      out_free;
  logic      advance;
  cfg_t      cfg;
  out_word_t res;

  // The event moves on, and the state commits, when the result register can take it.
  assign advance  = item_valid && out_free;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  usbrw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  usbrw_policy #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_policy (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  usbrw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sim/tb_usb_remote_wake_controller_top.sv]
// Self-checking testbench for usb_remote_wake_controller_top: a scoreboard class predicts
// every result word, tasks drive the event and register channels, and an initial
// block drives the result channel. Depends on usbrw_pkg and the controller RTL only.
module tb_usb_remote_wake_controller_top;
  import usbrw_pkg::*;

  // Event code that the block must ignore.
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned PHASE_COUNT = 6;

  // Scoreboard: its own copy of the wake policy, fed with every accepted event
  // word, and a queue of the result words those events must produce.
  class wake_scoreboard;
    logic        wake_en;
    logic [31:0] poff_delay;
    logic [31:0] req_timeout;
    phase_t      phase;
    logic        suspended;
    logic        resumed;
    logic [31:0] phase_start;
    logic [31:0] susp_at;
    logic        off;
    logic        owed;
    logic [7:0]  dpad;
    logic [7:0]  btn_a;
    logic [7:0]  btn_b;
    out_word_t   results_due[$];
    int unsigned mismatches;

    function new();
      wake_en     = 1'b1;
      poff_delay  = DEFAULT_DELAY_US;
      req_timeout = DEFAULT_DELAY_US;
      phase       = PH_IDLE;
      suspended   = 1'b0;
      resumed     = 1'b0;
      phase_start = '0;
      susp_at     = '0;
      off         = 1'b0;
      owed        = 1'b0;
      mismatches  = 0;
      clear_buttons();
    endfunction

    function void clear_buttons();
      dpad  = IDLE_DPAD;
      btn_a = 8'h00;
      btn_b = 8'h00;
    endfunction

    function void enter_phase(phase_t p, logic [31:0] now);
      phase       = p;
      phase_start = now;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] value);
      case (idx)
        CFG_WAKE_ENABLE:     wake_en = value[0];
        CFG_POWEROFF_DELAY:  poff_delay = value;
        CFG_REQUEST_TIMEOUT: req_timeout = value;
        default: ;
      endcase
    endfunction

    // A remote-wake attempt; a refusal only forces the wake while suspended.
    function void request_wake(logic [31:0] now, logic accepted, inout out_word_t r);
      if (wake_en) begin
        r.wake_request = 1'b1;
        if (accepted) begin
          enter_phase(PH_REQUESTED, now);
        end else if (suspended) begin
          r.wake_forced = 1'b1;
          enter_phase(PH_REQUESTED, now);
        end
      end
    endfunction

    function void note_event(in_word_t w);
      out_word_t r;
      phase_t    start_phase;
      logic      changed;
      logic      armed;
      r = '0;
      case (w.func)
        FN_TICK: begin
          start_phase = phase;
          if (suspended && !off && (w.now_us - susp_at) >= poff_delay) begin
            off         = 1'b1;
            r.power_off = 1'b1;
          end
          if (start_phase == PH_PENDING) begin
            if (!suspended) enter_phase(PH_DONE, w.now_us);
          end else if (start_phase == PH_REQUESTED) begin
            if (resumed || !suspended) enter_phase(PH_DONE, w.now_us);
            else if ((w.now_us - phase_start) > req_timeout) enter_phase(PH_DONE, w.now_us);
          end
        end
        FN_SUSPEND: begin
          suspended = 1'b1;
          resumed   = 1'b0;
          susp_at   = w.now_us;
          off       = 1'b0;
          enter_phase(PH_PENDING, w.now_us);
          clear_buttons();
        end
        FN_RESUME: begin
          if (off) owed = 1'b1;
          suspended = 1'b0;
          resumed   = 1'b1;
          susp_at   = '0;
          off       = 1'b0;
        end
        FN_CONNECT: begin
          if (suspended && phase != PH_REQUESTED)
            request_wake(w.now_us, w.wakeup_accepted, r);
        end
        FN_DISCONNECT: begin
          phase = PH_IDLE;
          clear_buttons();
        end
        FN_REPORT: begin
          if (w.report_len >= MIN_REPORT_LEN) begin
            changed = (w.dpad_byte != dpad) || (w.button_byte_a != btn_a) ||
                      (w.button_byte_b != btn_b);
            armed   = (phase != PH_REQUESTED);
            dpad    = w.dpad_byte;
            btn_a   = w.button_byte_a;
            btn_b   = w.button_byte_b;
            if (changed && armed && suspended)
              request_wake(w.now_us, w.wakeup_accepted, r);
          end
        end
        FN_TAKE: begin
          if (owed && !suspended) begin
            owed               = 1'b0;
            r.radio_wake_taken = 1'b1;
          end
        end
        default: ;
      endcase
      r.suspended_now = suspended;
      r.wake_phase    = phase;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [1:0] exp, logic [1:0] got);
      if (got !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (results_due.size() == 0) begin
        $error("result word arrived with no event outstanding");
        mismatches++;
      end else begin
        exp = results_due.pop_front();
        compare_field("wake_request", 2'(exp.wake_request), 2'(got.wake_request));
        compare_field("wake_forced", 2'(exp.wake_forced), 2'(got.wake_forced));
        compare_field("power_off", 2'(exp.power_off), 2'(got.power_off));
        compare_field("radio_wake_taken", 2'(exp.radio_wake_taken),
                      2'(got.radio_wake_taken));
        compare_field("suspended_now", 2'(exp.suspended_now), 2'(got.suspended_now));
        compare_field("wake_phase", exp.wake_phase, got.wake_phase);
      end
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction
  endclass

  // All inputs start at known values; from then on they change only through
  // nonblocking assignments right after a rising edge.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  wake_scoreboard board;
  // When set, neither side inserts gaps, so the block sees back-to-back words.
  bit          steady = 1'b0;
  int unsigned cycle_count = 0;
  // Free-running microsecond clock of the stimulus, and the last button bytes sent.
  logic [31:0] tb_now = '0;
  logic [7:0]  sent_dpad = IDLE_DPAD;
  logic [7:0]  sent_a = 8'h00;
  logic [7:0]  sent_b = 8'h00;

  usb_remote_wake_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_word_t make_event(logic [2:0] func, logic [31:0] now, logic [9:0] len,
                                          logic [7:0] b7, logic [7:0] b8, logic [7:0] b9,
                                          logic acc);
    in_word_t w;
    w.func            = func;
    w.now_us          = now;
    w.report_len      = len;
    w.dpad_byte       = b7;
    w.button_byte_a   = b8;
    w.button_byte_b   = b9;
    w.wakeup_accepted = acc;
    return w;
  endfunction

  // Offers one event word after a random gap and hands it to the scoreboard once
  // accepted. Valid stays high after acceptance; the next call either reuses it
  // for a back-to-back word or lowers it for its gap, so valid gets one update
  // per time step.
  task automatic send_event(in_word_t w);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_event(w);
  endtask

  // Stops the sender, waits until every outstanding result word is back, and
  // lets the two pipeline registers settle. The block is idle then.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers back to back; the block must be idle.
  task automatic program_regs(logic en, logic [31:0] poff, logic [31:0] tout);
    cfg_reg_t    idx [3];
    logic [31:0] val [3];
    idx = '{CFG_WAKE_ENABLE, CFG_POWEROFF_DELAY, CFG_REQUEST_TIMEOUT};
    val = '{{31'd0, en}, poff, tout};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random event. Time mostly moves forward by up to step_max microseconds so
  // that suspends, power-offs and request timeouts follow each other in order; a
  // few words carry an arbitrary timestamp as noise.
  task automatic send_random_event(logic [31:0] step_max);
    in_word_t    w;
    int unsigned pick;
    int unsigned bit_sel;
    logic [2:0]  func;
    logic [31:0] now;
    logic [9:0]  len;
    tb_now = tb_now + $urandom_range(0, step_max);
    now    = ($urandom_range(0, 24) == 0) ? $urandom() : tb_now;
    pick   = $urandom_range(0, 99);
    if (pick < 35)      func = FN_TICK;
    else if (pick < 43) func = FN_SUSPEND;
    else if (pick < 50) func = FN_RESUME;
    else if (pick < 60) func = FN_CONNECT;
    else if (pick < 64) func = FN_DISCONNECT;
    else if (pick < 88) func = FN_REPORT;
    else if (pick < 97) func = FN_TAKE;
    else                func = FN_UNUSED;
    // Reports repeat the previous buttons half the time, so that unchanged
    // reports are as common as changes; a change is often a single bit.
    case ($urandom_range(0, 3))
      0, 1: ;
      2: begin
        bit_sel = $urandom_range(0, 23);
        if (bit_sel < 8)       sent_dpad[bit_sel] = ~sent_dpad[bit_sel];
        else if (bit_sel < 16) sent_a[bit_sel - 8] = ~sent_a[bit_sel - 8];
        else                   sent_b[bit_sel - 16] = ~sent_b[bit_sel - 16];
      end
      default: begin
        sent_dpad = 8'($urandom());
        sent_a    = 8'($urandom());
        sent_b    = 8'($urandom());
      end
    endcase
    len = ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 9)) :
                                        10'($urandom_range(10, 1023));
    w   = make_event(func, now, len, sent_dpad, sent_a, sent_b, 1'($urandom_range(0, 1)));
    send_event(w);
  endtask

  // Result side: random stalls on out_ready, every accepted word checked.
  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end

  initial begin
    logic        en;
    logic [31:0] poff;
    logic [31:0] tout;
    logic [31:0] step_max;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_regs(1'b1, 32'd1000, 32'd500);

    // Directed part. Outside a suspend: a tick at time zero, a take with nothing
    // owed, the unused event code, a short report and a full-length report.
    send_event(make_event(FN_TICK, 32'd0, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TAKE, 32'd10, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_event(make_event(FN_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_event(make_event(FN_REPORT, 32'd20, 10'd9, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_event(make_event(FN_REPORT, 32'd30, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    // Suspend, then a button change that the core refuses: the wake is forced.
    send_event(make_event(FN_SUSPEND, 32'd100, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_REPORT, 32'd150, 10'd10, 8'h00, 8'h00, 8'h00, 1'b0));
    // The request times out, then a connect is accepted by the core.
    send_event(make_event(FN_TICK, 32'd700, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_CONNECT, 32'd800, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    // The suspend reaches the power-off delay exactly; only one pulse follows.
    send_event(make_event(FN_TICK, 32'd1100, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TICK, 32'd1200, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    // Resume after power-off leaves a radio wake owed, taken exactly once.
    send_event(make_event(FN_RESUME, 32'd1300, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TICK, 32'd1310, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TAKE, 32'd1320, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TAKE, 32'd1330, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_CONNECT, 32'd1340, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    // Power-off delay measured across the wrap of the timestamp.
    send_event(make_event(FN_SUSPEND, 32'hFFFF_FF00, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TICK, 32'h0000_02F0, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_DISCONNECT, 32'h0000_0300, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    drain_results();

    // With wake disabled, neither a button change nor a connect asks for wakeup.
    program_regs(1'b0, 32'd1000, 32'd500);
    send_event(make_event(FN_SUSPEND, 32'hFFFF_FFFF, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_REPORT, 32'd5, 10'd12, 8'h01, 8'h80, 8'h7F, 1'b1));
    send_event(make_event(FN_CONNECT, 32'd6, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_event(make_event(FN_TICK, 32'hFFFF_FFFF, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    drain_results();

    // Random part: one register setting per phase, the extremes among them. The
    // step size is matched to the delays so that power-offs and timeouts happen.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin en = 1'b1; poff = 32'd1000;       tout = 32'd500;        step_max = 32'd300; end
        1: begin en = 1'b1; poff = 32'd0;          tout = 32'd0;          step_max = 32'd2; end
        2: begin en = 1'b0; poff = 32'd300;        tout = 32'd200;        step_max = 32'd100; end
        3: begin en = 1'b1; poff = 32'hFFFF_FFFF;  tout = 32'hFFFF_FFFF;
                 step_max = 32'h4000_0000; end
        4: begin en = 1'b1; poff = DEFAULT_DELAY_US; tout = DEFAULT_DELAY_US;
                 step_max = 32'd2000000; end
        default: begin en = 1'b1; poff = 32'd50;   tout = 32'd2000;       step_max = 32'd400; end
      endcase
      drain_results();
      program_regs(en, poff, tout);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        // Halfway through, the sender holds off until the result side is empty.
        if (n == PHASE_ITEMS / 2) drain_results();
        send_random_event(step_max);
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
